// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL files. Each use sits on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk, switched off during reset.
`define CCP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define CCP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CCP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ccp_pkg.sv =====
package ccp_pkg;

    localparam int NUM_ITEMS  = 1024;
    localparam int COUNT_BITS = 20;
    localparam int ADDR_BITS  = $clog2(NUM_ITEMS);
    localparam int ITEM_BITS  = 10;
    localparam int W_BITS     = 11;
    localparam int PW_BITS    = W_BITS + 1;
    localparam int LPOS_BITS  = $clog2(PW_BITS);
    localparam int S_BITS     = 30;
    localparam int N_BITS     = 20;
    localparam int PEND_BITS  = 11;
    localparam int FRAC_BITS  = 24;
    localparam int REP_BITS   = 16;
    localparam int DELTA_BITS = 64;

    localparam logic [REP_BITS-1:0]   REP_RESET = 16'd8192;
    localparam logic [S_BITS-1:0]     S_MAX     = '1;
    localparam logic [N_BITS-1:0]     N_MAX     = '1;
    localparam logic [PEND_BITS-1:0]  PEND_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;

    // Actions.
    localparam logic [1:0] ACT_QADD = 2'd0;
    localparam logic [1:0] ACT_QDEL = 2'd1;
    localparam logic [1:0] ACT_ADD  = 2'd2;
    localparam logic [1:0] ACT_DEL  = 2'd3;

    // Error codes.
    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_ABSENT = 2'd1;
    localparam logic [1:0] ERR_SAT    = 2'd2;

    typedef logic [31:0] root_tab_t [FRAC_BITS];

    typedef struct packed {
        logic              start;
        logic [S_BITS-1:0] s;
        logic [N_BITS-1:0] n;
        logic [PW_BITS-1:0] w;
    } prof_req_t;

    typedef struct packed {
        logic                  done;
        logic [DELTA_BITS-1:0] value;
    } prof_rsp_t;

    // An absent item outranks a saturated count.
    function automatic logic [1:0] err_merge(input logic [1:0] cur, input logic [1:0] code);
        logic [1:0] res;
        res = cur;
        if (code == ERR_ABSENT)
        begin
            res = ERR_ABSENT;
        end
        else if (cur == ERR_OK)
        begin
            res = code;
        end
        return res;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] rem;
        r   = '0;
        b   = 64'd1 << 62;
        rem = v;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= r + b)
            begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Q.32 roots 2^(-1/2^(k+1)), each one taken from the truncated one before it.
    function automatic root_tab_t make_roots();
        root_tab_t  t;
        logic [63:0] c;
        c = isqrt64(64'd1 << 63);
        for (int k = 0; k < FRAC_BITS; k++)
        begin
            t[k] = c[31:0];
            c    = isqrt64(c << 32);
        end
        return t;
    endfunction

    localparam root_tab_t ROOTS = make_roots();

endpackage

// ===== hdl/ccp_ifs.sv =====
interface ccp_txn_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [9:0] item;
    logic       last;
    modport source (output valid, action, item, last, input ready);
    modport sink   (input valid, action, item, last, output ready);
endinterface

interface ccp_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] delta;
    logic [10:0] distinct_items;
    logic [29:0] total_items;
    logic [19:0] transactions;
    logic [1:0]  error;
    modport source (output valid, delta, distinct_items, total_items, transactions, error,
                    input ready);
    modport sink   (input valid, delta, distinct_items, total_items, transactions, error,
                    output ready);
endinterface

interface ccp_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] repulsion;
    modport source (output valid, repulsion, input ready);
    modport sink   (input valid, repulsion, output ready);
endinterface

// ===== hdl/clope_cluster_profit_top.sv =====
// One cluster of a CLOPE transaction clustering.
// Channels: txn takes one item id per beat with an action and a last mark; res gives
// one beat per transaction, at its last item, with the profit change (queries) or zero
// (commits), the cluster's W, S and N afterwards and an error code; cfg writes the
// repulsion exponent and is always ready, but should only be written while idle.
// Reset clears W, S, N and the pending sums at once, then runs a clearing pass over all
// 1024 entries of the occurrence table, during which txn is not ready.
// Each item goes through the table's read-modify-write (read at the accept beat, write
// back in the next cycle) before the next item is taken. A commit's last item then
// passes through the totals and the result register. A query's last item then waits for
// two profit evaluations, run one after the other in the shared profit unit, each made
// of 24 log squaring steps, 24 root multiplies and three product steps.
// The result sits in an output register: a stalled receiver holds it, and further
// items are still taken meanwhile; only a following last item waits for the register
// to free up.
module clope_cluster_profit_top
    import ccp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ccp_txn_if.sink   txn,
    ccp_res_if.source res,
    ccp_cfg_if.sink   cfg
);

    `include "assert_macros.svh"

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ITEM  = 3'd2;
    localparam logic [2:0] ST_FIN   = 3'd3;
    localparam logic [2:0] ST_OLD   = 3'd4;
    localparam logic [2:0] ST_NEW   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [ADDR_BITS:0]    clr_reg, clr_next;
    logic [REP_BITS-1:0]   rep_reg;
    logic [1:0]            act_reg, act_next;
    logic [ADDR_BITS-1:0]  addr_reg, addr_next;
    logic                  last_reg, last_next;
    logic [W_BITS-1:0]     w_reg, w_next;
    logic [S_BITS-1:0]     s_reg, s_next;
    logic [N_BITS-1:0]     n_reg, n_next;
    logic [PEND_BITS-1:0]  len_reg, len_next;
    logic [PEND_BITS-1:0]  pdc_reg, pdc_next;
    logic [1:0]            err_reg, err_next;
    logic [S_BITS-1:0]     s2_reg, s2_next;
    logic [N_BITS-1:0]     n2_reg, n2_next;
    logic [PW_BITS-1:0]    w2_reg, w2_next;
    logic [DELTA_BITS-1:0] old_reg, old_next;
    logic [DELTA_BITS-1:0] delta_reg, delta_next;
    logic                  rv_reg, rv_next;
    logic [DELTA_BITS-1:0] od_reg, od_next;
    logic [W_BITS-1:0]     ow_reg, ow_next;
    logic [S_BITS-1:0]     os_reg, os_next;
    logic [N_BITS-1:0]     on_reg, on_next;
    logic [1:0]            oe_reg, oe_next;

    logic                  accept;
    logic                  out_load;
    logic                  ram_we;
    logic [ADDR_BITS-1:0]  ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [COUNT_BITS-1:0] cnt;
    logic [S_BITS:0]       s_sum;
    logic                  is_query;
    logic                  add_like;
    prof_req_t             preq;
    prof_rsp_t             prsp;

    assign accept    = txn.valid && txn.ready;
    assign txn.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign out_load  = (state_reg == ST_OUT) && (!rv_reg || res.ready);
    assign s_sum     = {1'b0, s_reg} + (S_BITS + 1)'(len_reg);
    assign is_query  = (act_reg == ACT_QADD) || (act_reg == ACT_QDEL);
    assign add_like  = (act_reg == ACT_QADD) || (act_reg == ACT_ADD);

    ccp_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_ITEMS)
    ) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (txn.item[ADDR_BITS-1:0]),
        .rdata (cnt)
    );

    ccp_profit u_profit (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (preq),
        .repulsion (rep_reg),
        .rsp       (prsp)
    );

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        act_next   = act_reg;
        addr_next  = addr_reg;
        last_next  = last_reg;
        w_next     = w_reg;
        s_next     = s_reg;
        n_next     = n_reg;
        len_next   = len_reg;
        pdc_next   = pdc_reg;
        err_next   = err_reg;
        s2_next    = s2_reg;
        n2_next    = n2_reg;
        w2_next    = w2_reg;
        old_next   = old_reg;
        delta_next = delta_reg;
        ram_we     = 1'b0;
        ram_waddr  = addr_reg;
        ram_wdata  = '0;
        preq       = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                // Zero the table one entry a cycle.
                ram_we    = 1'b1;
                ram_waddr = clr_reg[ADDR_BITS-1:0];
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == (ADDR_BITS + 1)'(NUM_ITEMS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next   = txn.action;
                    addr_next  = txn.item[ADDR_BITS-1:0];
                    last_next  = txn.last;
                    state_next = ST_ITEM;
                end
            end
            ST_ITEM:
            begin
                // The count read at the accept beat is valid now; adds and deletes write back the changed count.
                if (len_reg != PEND_MAX)
                begin
                    len_next = len_reg + 1'b1;
                end
                unique case (act_reg)
                    ACT_QADD:
                    begin
                        if (cnt == '0 && pdc_reg != PEND_MAX)
                        begin
                            pdc_next = pdc_reg + 1'b1;
                        end
                    end
                    ACT_QDEL:
                    begin
                        if (cnt == '0)
                        begin
                            err_next = err_merge(err_reg, ERR_ABSENT);
                        end
                        else if (cnt == COUNT_BITS'(1) && pdc_reg != PEND_MAX)
                        begin
                            pdc_next = pdc_reg + 1'b1;
                        end
                    end
                    ACT_ADD:
                    begin
                        if (cnt == CNT_MAX)
                        begin
                            err_next = err_merge(err_reg, ERR_SAT);
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = cnt + 1'b1;
                            if (cnt == '0)
                            begin
                                w_next = w_reg + 1'b1;
                            end
                        end
                    end
                    ACT_DEL:
                    begin
                        if (cnt == '0)
                        begin
                            err_next = err_merge(err_reg, ERR_ABSENT);
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = cnt - 1'b1;
                            if (cnt == COUNT_BITS'(1) && w_reg != '0)
                            begin
                                w_next = w_reg - 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                if (add_like)
                begin
                    if (s_sum > (S_BITS + 1)'(S_MAX))
                    begin
                        s2_next  = S_MAX;
                        err_next = err_merge(err_reg, ERR_SAT);
                    end
                    else
                    begin
                        s2_next = s_sum[S_BITS-1:0];
                    end
                    if (n_reg == N_MAX)
                    begin
                        n2_next  = N_MAX;
                        err_next = err_merge(err_merge(err_reg, ERR_SAT), err_next);
                    end
                    else
                    begin
                        n2_next = n_reg + 1'b1;
                    end
                end
                else
                begin
                    if (s_reg < S_BITS'(len_reg))
                    begin
                        s2_next  = '0;
                        err_next = err_merge(err_reg, ERR_ABSENT);
                    end
                    else
                    begin
                        s2_next = s_reg - S_BITS'(len_reg);
                    end
                    if (n_reg == '0)
                    begin
                        n2_next  = '0;
                        err_next = err_merge(err_reg, ERR_ABSENT);
                    end
                    else
                    begin
                        n2_next = n_reg - 1'b1;
                    end
                end
                if (act_reg == ACT_QADD)
                begin
                    w2_next = PW_BITS'(w_reg) + PW_BITS'(pdc_reg);
                end
                else
                begin
                    w2_next = (w_reg >= pdc_reg) ? PW_BITS'(w_reg - pdc_reg) : '0;
                end
                if (is_query)
                begin
                    preq.start = 1'b1;
                    preq.s     = s_reg;
                    preq.n     = n_reg;
                    preq.w     = PW_BITS'(w_reg);
                    state_next = ST_OLD;
                end
                else
                begin
                    s_next     = s2_next;
                    n_next     = n2_next;
                    delta_next = '0;
                    state_next = ST_OUT;
                end
            end
            ST_OLD:
            begin
                if (prsp.done)
                begin
                    old_next   = prsp.value;
                    preq.start = 1'b1;
                    preq.s     = s2_reg;
                    preq.n     = n2_reg;
                    preq.w     = w2_reg;
                    state_next = ST_NEW;
                end
            end
            ST_NEW:
            begin
                if (prsp.done)
                begin
                    delta_next = prsp.value - old_reg;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    len_next   = '0;
                    pdc_next   = '0;
                    err_next   = ERR_OK;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: loads the finished transaction, holds it while the receiver stalls.
    always_comb
    begin
        rv_next = out_load || (rv_reg && !res.ready);
        od_next = od_reg;
        ow_next = ow_reg;
        os_next = os_reg;
        on_next = on_reg;
        oe_next = oe_reg;
        if (out_load)
        begin
            od_next = delta_reg;
            ow_next = w_reg;
            os_next = s_reg;
            on_next = n_reg;
            oe_next = err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            rep_reg   <= REP_RESET;
            w_reg     <= '0;
            s_reg     <= '0;
            n_reg     <= '0;
            len_reg   <= '0;
            pdc_reg   <= '0;
            err_reg   <= ERR_OK;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cfg.valid && cfg.ready)
            begin
                rep_reg <= cfg.repulsion;
            end
            w_reg     <= w_next;
            s_reg     <= s_next;
            n_reg     <= n_next;
            len_reg   <= len_next;
            pdc_reg   <= pdc_next;
            err_reg   <= err_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        addr_reg  <= addr_next;
        last_reg  <= last_next;
        s2_reg    <= s2_next;
        n2_reg    <= n2_next;
        w2_reg    <= w2_next;
        old_reg   <= old_next;
        delta_reg <= delta_next;
        od_reg    <= od_next;
        ow_reg    <= ow_next;
        os_reg    <= os_next;
        on_reg    <= on_next;
        oe_reg    <= oe_next;
    end

    assign res.valid          = rv_reg;
    assign res.delta          = od_reg;
    assign res.distinct_items = ow_reg;
    assign res.total_items    = os_reg;
    assign res.transactions   = on_reg;
    assign res.error          = oe_reg;

    `CCP_ASSERT(a_w_bound, w_reg <= W_BITS'(NUM_ITEMS), "distinct count above table size")
    `CCP_ASSERT_NXT(a_item_once, state_reg == ST_ITEM, state_reg != ST_ITEM, "item stage held")
    `CCP_ASSERT_IMP(a_commit_zero, out_load && !is_query, delta_reg == '0, "commit delta nonzero")
    `CCP_ASSERT_IMP(a_err_code, res.valid, (res.error == ERR_OK) || (res.error == ERR_ABSENT) || (res.error == ERR_SAT), "bad error code")

endmodule

// ===== hdl/ccp_ram.sv =====
module ccp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/ccp_profit.sv =====
module ccp_profit
    import ccp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  prof_req_t           req,
    input  logic [REP_BITS-1:0] repulsion,
    output prof_rsp_t           rsp
);

    `include "assert_macros.svh"

    localparam logic [2:0] P_IDLE  = 3'd0;
    localparam logic [2:0] P_LOG   = 3'd1;
    localparam logic [2:0] P_EXP   = 3'd2;
    localparam logic [2:0] P_MANT  = 3'd3;
    localparam logic [2:0] P_PMUL  = 3'd4;
    localparam logic [2:0] P_PP0   = 3'd5;
    localparam logic [2:0] P_PP1   = 3'd6;
    localparam logic [2:0] P_SHIFT = 3'd7;
    localparam logic [4:0] LAST_STEP = 5'(FRAC_BITS - 1);

    logic [2:0]           state_reg, state_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic [S_BITS-1:0]    s_reg, s_next;
    logic [N_BITS-1:0]    n_reg, n_next;
    logic [LPOS_BITS-1:0] lpos_reg, lpos_next;
    logic [30:0]          x_reg, x_next;
    logic [FRAC_BITS-1:0] frac_reg, frac_next;
    logic [7:0]           ei_reg, ei_next;
    logic [FRAC_BITS-1:0] f_reg, f_next;
    logic [32:0]          mant_reg, mant_next;
    logic [49:0]          p_reg, p_next;
    logic [82:0]          prod_reg, prod_next;
    logic [63:0]          value_reg, value_next;
    logic                 done_reg, done_next;

    logic [LPOS_BITS-1:0] lpos;
    logic [61:0]          sq;
    logic [43:0]          e;
    logic [64:0]          mprod;
    logic [57:0]          pp_lo;
    logic [57:0]          pp_hi;
    logic [8:0]           sh_amt;
    logic [82:0]          full;

    always_comb
    begin
        lpos = '0;
        for (int i = 0; i < PW_BITS; i++)
        begin
            if (req.w[i])
            begin
                lpos = LPOS_BITS'(i);
            end
        end
    end

    assign sq     = x_reg * x_reg;
    assign e      = repulsion * {lpos_reg, frac_reg};
    assign mprod  = mant_reg * ROOTS[cnt_reg];
    assign pp_lo  = p_reg[24:0] * mant_reg;
    assign pp_hi  = p_reg[49:25] * mant_reg;
    assign sh_amt = 9'(ei_reg) + 9'd16;
    assign full   = prod_reg >> sh_amt;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_next     = s_reg;
        n_next     = n_reg;
        lpos_next  = lpos_reg;
        x_next     = x_reg;
        frac_next  = frac_reg;
        ei_next    = ei_reg;
        f_next     = f_reg;
        mant_next  = mant_reg;
        p_next     = p_reg;
        prod_next  = prod_reg;
        value_next = value_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            P_IDLE:
            begin
                if (req.start)
                begin
                    if (req.w == '0 || req.s == '0 || req.n == '0)
                    begin
                        value_next = '0;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        s_next     = req.s;
                        n_next     = req.n;
                        lpos_next  = lpos;
                        x_next     = 31'(req.w) << (5'd30 - 5'(lpos));
                        frac_next  = '0;
                        cnt_next   = '0;
                        state_next = P_LOG;
                    end
                end
            end
            P_LOG:
            begin
                // Squaring doubles the log; an overflow past 2 yields one fraction bit.
                frac_next = {frac_reg[FRAC_BITS-2:0], sq[61]};
                x_next    = sq[61] ? sq[61:31] : sq[60:30];
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = P_EXP;
                end
            end
            P_EXP:
            begin
                ei_next    = e[43:36];
                f_next     = e[35:12];
                mant_next  = 33'd1 << 32;
                cnt_next   = '0;
                state_next = P_MANT;
            end
            P_MANT:
            begin
                if (f_reg[FRAC_BITS-1])
                begin
                    mant_next = mprod[64:32];
                end
                f_next   = f_reg << 1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = P_PMUL;
                end
            end
            P_PMUL:
            begin
                p_next     = s_reg * n_reg;
                state_next = P_PP0;
            end
            P_PP0:
            begin
                prod_next  = 83'(pp_lo);
                state_next = P_PP1;
            end
            P_PP1:
            begin
                prod_next  = prod_reg + ({25'b0, pp_hi} << 25);
                state_next = P_SHIFT;
            end
            P_SHIFT:
            begin
                value_next = (|full[82:63]) ? {1'b0, {63{1'b1}}} : {1'b0, full[62:0]};
                done_next  = 1'b1;
                state_next = P_IDLE;
            end
            default:
            begin
                state_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg     <= s_next;
        n_reg     <= n_next;
        lpos_reg  <= lpos_next;
        x_reg     <= x_next;
        frac_reg  <= frac_next;
        ei_reg    <= ei_next;
        f_reg     <= f_next;
        mant_reg  <= mant_next;
        p_reg     <= p_next;
        prod_reg  <= prod_next;
        value_reg <= value_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;

    `CCP_ASSERT_IMP(a_start_idle, req.start, state_reg == P_IDLE, "profit start while busy")
    `CCP_ASSERT_IMP(a_value_pos, done_reg, !value_reg[63], "profit value negative")
    `CCP_ASSERT_NXT(a_shift_done, state_reg == P_SHIFT, done_reg, "profit done missing")

endmodule

// ===== tb/clope_cluster_profit_top_tb.sv =====
`timescale 1ns / 100ps

module clope_cluster_profit_top_tb;
    import ccp_pkg::*;

    // Cluster totals carried by one result beat.
    typedef struct {
        logic [63:0] delta;
        logic [10:0] w;
        logic [29:0] s;
        logic [19:0] n;
        logic [1:0]  err;
    } cluster_res_t;

    // One row of the directed table. Rows with known set carry a hand-written result.
    typedef struct {
        logic [1:0]  act;
        logic [9:0]  item;
        logic        last;
        bit          known;
        cluster_res_t res;
    } txn_row_t;

    logic clk;
    logic rst_n;

    ccp_txn_if txn ();
    ccp_res_if res ();
    ccp_cfg_if cfg ();

    clope_cluster_profit_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .txn   (txn),
        .res   (res),
        .cfg   (cfg)
    );

    // Shadow copy of the cluster, kept in step with every accepted beat.
    logic [19:0] occ_count [1024];
    logic [10:0] w_cnt;
    logic [29:0] s_cnt;
    logic [19:0] n_cnt;
    logic [10:0] run_len;
    logic [10:0] run_w_chg;
    logic [1:0]  run_err;
    logic [15:0] rep_exp;

    cluster_res_t cluster_q[$];
    int errors;
    int sent_items;

    // Idling odds in percent, set by the stimulus process only.
    int snd_idle;
    int rcv_idle;
    // The stimulus toggles hold_tog to ask the receiver for a long stall.
    bit hold_tog;
    bit hold_seen;
    int hold_left;

    always #4 clk = ~clk;

    // Floor square root, one result bit at a time from the top.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
            begin
                r = t;
            end
        end
        return r;
    endfunction

    // S*N / W^r in Q.16, with W^r taken through a truncated log2 and root chain.
    function automatic logic [63:0] profit_q16(input logic [29:0] s, input logic [19:0] n,
                                               input logic [11:0] w);
        logic [63:0]  sn;
        logic [63:0]  x;
        logic [63:0]  lg;
        logic [63:0]  e;
        logic [63:0]  ei;
        logic [23:0]  f;
        logic [63:0]  mant;
        logic [63:0]  root;
        logic [127:0] prod;
        logic [127:0] v;
        int msb;
        if (w == 0 || s == 0 || n == 0)
        begin
            return 64'd0;
        end
        sn = 64'(s) * 64'(n);
        msb = 0;
        for (int i = 0; i < 12; i++)
        begin
            if (w[i])
            begin
                msb = i;
            end
        end
        x = 64'(w) << (30 - msb);
        lg = 64'(msb) << 24;
        for (int i = 23; i >= 0; i--)
        begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30))
            begin
                lg[i] = 1'b1;
                x = x >> 1;
            end
        end
        e = 64'(rep_exp) * lg;
        ei = e >> 36;
        f = e[35:12];
        mant = 64'd1 << 32;
        root = floor_sqrt(64'd1 << 63);
        for (int k = 23; k >= 0; k--)
        begin
            if (f[k])
            begin
                mant = (mant * root) >> 32;
            end
            root = floor_sqrt(root << 32);
        end
        prod = 128'(sn) * 128'(mant);
        if (ei + 16 >= 128)
        begin
            return 64'd0;
        end
        v = prod >> (ei + 16);
        if (v > 128'h7FFF_FFFF_FFFF_FFFF)
        begin
            return 64'h7FFF_FFFF_FFFF_FFFF;
        end
        return v[63:0];
    endfunction

    function automatic logic [1:0] worse_err(input logic [1:0] cur, input logic [1:0] code);
        if (code == ERR_ABSENT || cur == ERR_OK)
        begin
            return code;
        end
        return cur;
    endfunction

    // Applies one accepted beat to the shadow cluster; got is set at a last item.
    task automatic cluster_step(input logic [1:0] act, input logic [9:0] item,
                                input logic last, output bit got, output cluster_res_t r);
        logic [19:0] c;
        logic [29:0] s2;
        logic [19:0] n2;
        logic [11:0] w2;
        c = occ_count[item];
        got = 1'b0;
        r = '{default: '0};
        if (run_len != PEND_MAX)
        begin
            run_len = run_len + 1'b1;
        end
        case (act)
            ACT_QADD:
            begin
                if (c == 0 && run_w_chg != PEND_MAX)
                begin
                    run_w_chg = run_w_chg + 1'b1;
                end
            end
            ACT_QDEL:
            begin
                if (c == 0)
                begin
                    run_err = worse_err(run_err, ERR_ABSENT);
                end
                else if (c == 1 && run_w_chg != PEND_MAX)
                begin
                    run_w_chg = run_w_chg + 1'b1;
                end
            end
            ACT_ADD:
            begin
                if (c == CNT_MAX)
                begin
                    run_err = worse_err(run_err, ERR_SAT);
                end
                else
                begin
                    occ_count[item] = c + 1'b1;
                    if (c == 0)
                    begin
                        w_cnt = w_cnt + 1'b1;
                    end
                end
            end
            default:
            begin
                if (c == 0)
                begin
                    run_err = worse_err(run_err, ERR_ABSENT);
                end
                else
                begin
                    occ_count[item] = c - 1'b1;
                    if (c == 1 && w_cnt != 0)
                    begin
                        w_cnt = w_cnt - 1'b1;
                    end
                end
            end
        endcase
        if (last)
        begin
            if (act == ACT_QADD || act == ACT_ADD)
            begin
                if (s_cnt > S_MAX - 30'(run_len))
                begin
                    s2 = S_MAX;
                    run_err = worse_err(run_err, ERR_SAT);
                end
                else
                begin
                    s2 = s_cnt + 30'(run_len);
                end
                if (n_cnt == N_MAX)
                begin
                    n2 = N_MAX;
                    run_err = worse_err(run_err, ERR_SAT);
                end
                else
                begin
                    n2 = n_cnt + 1'b1;
                end
            end
            else
            begin
                if (s_cnt < 30'(run_len))
                begin
                    s2 = '0;
                    run_err = worse_err(run_err, ERR_ABSENT);
                end
                else
                begin
                    s2 = s_cnt - 30'(run_len);
                end
                if (n_cnt == 0)
                begin
                    n2 = '0;
                    run_err = worse_err(run_err, ERR_ABSENT);
                end
                else
                begin
                    n2 = n_cnt - 1'b1;
                end
            end
            if (act == ACT_QADD || act == ACT_QDEL)
            begin
                if (act == ACT_QADD)
                begin
                    w2 = 12'(w_cnt) + 12'(run_w_chg);
                end
                else
                begin
                    w2 = (w_cnt >= run_w_chg) ? 12'(w_cnt - run_w_chg) : 12'd0;
                end
                r.delta = profit_q16(s2, n2, w2) - profit_q16(s_cnt, n_cnt, 12'(w_cnt));
            end
            else
            begin
                s_cnt = s2;
                n_cnt = n2;
            end
            r.w = w_cnt;
            r.s = s_cnt;
            r.n = n_cnt;
            r.err = run_err;
            run_len = '0;
            run_w_chg = '0;
            run_err = ERR_OK;
            got = 1'b1;
        end
    endtask

    // Offers one beat, with a random gap first, and waits for it to be taken.
    task automatic send_beat(input logic [1:0] act, input logic [9:0] item, input logic last,
                             input bit known, input cluster_res_t typed);
        bit got;
        cluster_res_t r;
        if ($urandom_range(99) < snd_idle)
        begin
            @(negedge clk);
            txn.valid <= 1'b0;
            repeat ($urandom_range(3)) @(negedge clk);
        end
        @(negedge clk);
        txn.valid <= 1'b1;
        txn.action <= act;
        txn.item <= item;
        txn.last <= last;
        @(posedge clk);
        while (!txn.ready)
        begin
            @(posedge clk);
        end
        cluster_step(act, item, last, got, r);
        sent_items++;
        if (got)
        begin
            cluster_q.push_back(known ? typed : r);
        end
    endtask

    task automatic send_plain(input logic [1:0] act, input logic [9:0] item, input logic last);
        send_beat(act, item, last, 1'b0, '{default: '0});
    endtask

    task automatic write_repulsion(input logic [15:0] value);
        @(negedge clk);
        txn.valid <= 1'b0;
        cfg.valid <= 1'b1;
        cfg.repulsion <= value;
        @(posedge clk);
        while (!cfg.ready)
        begin
            @(posedge clk);
        end
        rep_exp = value;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Waits until every result is back, then lets the clock run on with no input.
    task automatic drain();
        @(negedge clk);
        txn.valid <= 1'b0;
        wait (cluster_q.size() == 0);
        repeat (300) @(posedge clk);
    endtask

    // Picks an item, mostly from a small pool so that counts build up.
    function automatic logic [9:0] pick_item();
        if ($urandom_range(9) == 0)
        begin
            return 10'($urandom_range(1023));
        end
        return 10'($urandom_range(15));
    endfunction

    // Random transactions: mostly well-formed commits and queries, some noise.
    task automatic random_txns(input int budget);
        int stop_at;
        int kind;
        int len;
        logic [1:0] act;
        logic [9:0] item;
        stop_at = sent_items + budget;
        while (sent_items < stop_at)
        begin
            kind = $urandom_range(99);
            len = $urandom_range(1, 5);
            if (kind < 40)
            begin
                act = ACT_ADD;
            end
            else if (kind < 55)
            begin
                act = ACT_DEL;
            end
            else if (kind < 75)
            begin
                act = ACT_QADD;
            end
            else
            begin
                act = ACT_QDEL;
            end
            for (int i = 0; i < len; i++)
            begin
                item = pick_item();
                // Deletes and delete queries look for an item that is present.
                if (act == ACT_DEL || act == ACT_QDEL)
                begin
                    for (int t = 0; t < 20 && occ_count[item] == 0; t++)
                    begin
                        item = pick_item();
                    end
                end
                // Noise: a random action on a random item.
                if (kind >= 92)
                begin
                    send_plain(2'($urandom_range(3)), 10'($urandom_range(1023)), i == len - 1);
                end
                else
                begin
                    send_plain(act, item, i == len - 1);
                end
            end
        end
    endtask

    // Result side: random stalls, plus the long hold-off that the stimulus asks for.
    always @(negedge clk)
    begin
        if (hold_tog != hold_seen)
        begin
            hold_seen <= hold_tog;
            hold_left <= 400;
            res.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            res.ready <= 1'b0;
        end
        else
        begin
            res.ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    // Every result beat is checked against the oldest outstanding prediction.
    always @(posedge clk)
    begin
        cluster_res_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (cluster_q.size() == 0)
            begin
                $display("%0t: unexpected result beat, delta %h", $time, res.delta);
                errors++;
            end
            else
            begin
                want = cluster_q.pop_front();
                if (res.delta !== want.delta)
                begin
                    $display("%0t: delta expected %h actual %h", $time, want.delta, res.delta);
                    errors++;
                end
                if (res.distinct_items !== want.w)
                begin
                    $display("%0t: distinct_items expected %0d actual %0d", $time, want.w,
                             res.distinct_items);
                    errors++;
                end
                if (res.total_items !== want.s)
                begin
                    $display("%0t: total_items expected %0d actual %0d", $time, want.s,
                             res.total_items);
                    errors++;
                end
                if (res.transactions !== want.n)
                begin
                    $display("%0t: transactions expected %0d actual %0d", $time, want.n,
                             res.transactions);
                    errors++;
                end
                if (res.error !== want.err)
                begin
                    $display("%0t: error expected %0d actual %0d", $time, want.err, res.error);
                    errors++;
                end
            end
        end
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #4000000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        txn_row_t rows [16];
        logic [15:0] rep_set [5];
        clk = 1'b0;
        rst_n = 1'b0;
        txn.valid = 1'b0;
        txn.action = ACT_QADD;
        txn.item = '0;
        txn.last = 1'b0;
        res.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.repulsion = '0;
        errors = 0;
        sent_items = 0;
        snd_idle = 29;
        rcv_idle = 82;
        hold_tog = 1'b0;
        hold_seen = 1'b0;
        hold_left = 0;
        foreach (occ_count[i])
        begin
            occ_count[i] = '0;
        end
        w_cnt = '0;
        s_cnt = '0;
        n_cnt = '0;
        run_len = '0;
        run_w_chg = '0;
        run_err = ERR_OK;
        rep_exp = REP_RESET;

        // Directed part. Known results: queries and deletes on an empty cluster,
        // the first commits, and a delete that runs the cluster below empty.
        rows = '{
            '{ACT_QDEL, 10'd5,    1'b1, 1'b1, '{64'd0, 11'd0, 30'd0, 20'd0, ERR_ABSENT}},
            '{ACT_DEL,  10'd5,    1'b1, 1'b1, '{64'd0, 11'd0, 30'd0, 20'd0, ERR_ABSENT}},
            '{ACT_ADD,  10'd0,    1'b0, 1'b0, '{default: '0}},
            '{ACT_ADD,  10'd1023, 1'b1, 1'b1, '{64'd0, 11'd2, 30'd2, 20'd1, ERR_OK}},
            '{ACT_QADD, 10'd0,    1'b0, 1'b0, '{default: '0}},
            '{ACT_QADD, 10'd512,  1'b1, 1'b0, '{default: '0}},
            '{ACT_QDEL, 10'd0,    1'b1, 1'b0, '{default: '0}},
            '{ACT_ADD,  10'd1023, 1'b1, 1'b1, '{64'd0, 11'd2, 30'd3, 20'd2, ERR_OK}},
            '{ACT_QDEL, 10'd1023, 1'b1, 1'b0, '{default: '0}},
            '{ACT_DEL,  10'd1023, 1'b1, 1'b1, '{64'd0, 11'd2, 30'd2, 20'd1, ERR_OK}},
            '{ACT_DEL,  10'd0,    1'b1, 1'b1, '{64'd0, 11'd1, 30'd1, 20'd0, ERR_OK}},
            '{ACT_DEL,  10'd1023, 1'b0, 1'b0, '{default: '0}},
            '{ACT_DEL,  10'd7,    1'b1, 1'b1, '{64'd0, 11'd0, 30'd0, 20'd0, ERR_ABSENT}},
            '{ACT_QADD, 10'd3,    1'b0, 1'b0, '{default: '0}},
            '{ACT_ADD,  10'd682,  1'b0, 1'b0, '{default: '0}},
            '{ACT_ADD,  10'd341,  1'b1, 1'b0, '{default: '0}}
        };
        // Repulsion per phase: reset value, both extremes, a plain one, a random one.
        rep_set = '{REP_RESET, 16'd0, 16'hFFFF, 16'd4096, 16'($urandom_range(65535))};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            send_beat(rows[i].act, rows[i].item, rows[i].last, rows[i].known, rows[i].res);
        end

        for (int phase = 0; phase < 5; phase++)
        begin
            // Sender slow and receiver slower, then the other way round, then full speed.
            if (phase < 2)
            begin
                snd_idle = 29;
                rcv_idle = 82;
            end
            else if (phase < 4)
            begin
                snd_idle = 82;
                rcv_idle = 29;
            end
            else
            begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            if (phase > 0)
            begin
                drain();
                write_repulsion(rep_set[phase]);
            end
            if (phase == 1)
            begin
                // A long add query over items spread across the whole table.
                for (int i = 0; i < 60; i++)
                begin
                    send_plain(ACT_QADD, 10'($urandom_range(1023)), i == 59);
                end
            end
            if (phase == 4)
            begin
                // Long receiver stall while items keep coming, so the input backs up.
                hold_tog = ~hold_tog;
            end
            random_txns(55);
            if (phase == 2)
            begin
                // Sender waits until every result has come back, then goes on.
                @(negedge clk);
                txn.valid <= 1'b0;
                wait (cluster_q.size() == 0);
            end
            random_txns(55);
        end

        @(negedge clk);
        txn.valid <= 1'b0;
        wait (cluster_q.size() == 0);
        repeat (300) @(posedge clk);
        if (errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ccp_pkg.sv
hdl/ccp_ifs.sv
hdl/ccp_ram.sv
hdl/ccp_profit.sv
hdl/clope_cluster_profit_top.sv
tb/clope_cluster_profit_top_tb.sv
